// ===== rtl/nipd_pkg.sv =====
// Shared types and constants for the NEC infrared pulse decoder.
// Holds the beat payload structs, status and register codes and the key table.
// No dependencies.
package nipd_pkg;

	localparam int CODE_BITS_DEF = 32;
	localparam int TABLE_ROWS = 17;
	localparam int KEY_COUNT = 17;
	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W = 16;

	// Nominal timings in microseconds
	localparam logic [13:0] LEADER_MARK_US = 14'd9000;
	localparam logic [13:0] LEADER_SPACE_US = 14'd4500;
	localparam logic [13:0] BIT_SHORT_US = 14'd560;
	localparam logic [13:0] BIT_LONG_US = 14'd1690;

	localparam logic [15:0] ADDR_RESET = 16'hFF00;
	localparam logic [11:0] LEADER_MARK_TOL_RESET = 12'd1000;
	localparam logic [10:0] LEADER_SPACE_TOL_RESET = 11'd500;
	localparam logic [8:0] BIT_TOL_RESET = 9'd200;

	localparam logic [7:0] NO_CHAR = 8'hFF;

	typedef enum logic {
		CMD_CAPTURE = 1'b0,
		CMD_TIMEOUT = 1'b1
	} cmd_t;

	typedef enum logic [2:0] {
		ST_OK = 3'd0,
		ST_IDLE = 3'd1,
		ST_LEADER = 3'd2,
		ST_MARK = 3'd3,
		ST_SPACE = 3'd4,
		ST_ADDR = 3'd5,
		ST_KEY = 3'd6
	} status_t;

	typedef enum logic [CFG_INDEX_W-1:0] {
		CFG_ADDRESS = 2'd0,
		CFG_LEADER_MARK_TOL = 2'd1,
		CFG_LEADER_SPACE_TOL = 2'd2,
		CFG_BIT_TOL = 2'd3
	} cfg_index_t;

	typedef struct packed {
		cmd_t cmd;
		logic [15:0] interval_us;
	} in_beat_t;

	typedef struct packed {
		status_t status;
		logic [4:0] key_index;
		logic [7:0] key_char;
		logic [31:0] received_code;
	} out_beat_t;

	// Verdict of the address and key check on a complete frame
	typedef struct packed {
		status_t status;
		logic [4:0] row;
		logic [7:0] key_char;
	} check_t;

	localparam logic [7:0] KEY_CMD [TABLE_ROWS] = '{
		8'h45, 8'h46, 8'h47, 8'h44, 8'h40, 8'h43, 8'h07, 8'h15, 8'h09,
		8'h16, 8'h19, 8'h0D, 8'h18, 8'h08, 8'h1C, 8'h5A, 8'h52
	};

	// "123456789*0#+LOR-"
	localparam logic [7:0] KEY_CHAR [TABLE_ROWS] = '{
		8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37, 8'h38, 8'h39,
		8'h2A, 8'h30, 8'h23, 8'h2B, 8'h4C, 8'h4F, 8'h52, 8'h2D
	};

endpackage

// ===== rtl/nipd_frame_check.sv =====
// Address compare and command lookup on a received 32-bit code.
// Depends on nipd_pkg for the key table and check_t.
module nipd_frame_check import nipd_pkg::*; (
	input logic [31:0] code,
	input logic [15:0] expected_address,
	output check_t verdict
);

	logic [7:0] cmd_byte;
	logic [7:0] inv_byte;
	logic hit;
	logic [4:0] hit_row;
	logic [7:0] hit_char;

	assign cmd_byte = code[23:16];
	assign inv_byte = code[31:24];

	// Lowest matching row wins
	always_comb begin
		hit = 1'b0;
		hit_row = '0;
		hit_char = NO_CHAR;
		for (int i = 0; i < TABLE_ROWS; i++) begin
			if (i < KEY_COUNT && !hit && cmd_byte == KEY_CMD[i]
					&& inv_byte == ~KEY_CMD[i]) begin
				hit = 1'b1;
				hit_row = 5'(i);
				hit_char = KEY_CHAR[i];
			end
		end
	end

	always_comb begin
		verdict.status = ST_KEY;
		verdict.row = '0;
		verdict.key_char = NO_CHAR;
		if (code[15:0] != expected_address) begin
			verdict.status = ST_ADDR;
		end else if (hit) begin
			verdict.status = ST_OK;
			verdict.row = hit_row;
			verdict.key_char = hit_char;
		end
	end

endmodule

// ===== rtl/nec_ir_pulse_decoder_unit.sv =====
// NEC IR pulse decoder: one beat per cycle unless stalled; a capture beat makes no
// result, a timeout beat gives its result through the input register and then the
// result register. Input stalls only while a timeout sits in the input register and
// the held result is stalled. Reset clears frame state and handshakes and restores
// register defaults. Depends on nipd_pkg and nipd_frame_check.
module nec_ir_pulse_decoder_unit import nipd_pkg::*; #(
	parameter int CODE_BITS = CODE_BITS_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	input in_beat_t in_data,
	output logic out_valid,
	input logic out_stall,
	output out_beat_t out_data,
	input logic cfg_valid,
	output logic cfg_ready,
	input cfg_index_t cfg_index,
	input logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int BCW = $clog2(CODE_BITS + 1);
	localparam logic [BCW-1:0] BC_MAX = BCW'(CODE_BITS);
	localparam logic [1:0] CAP_SAT = 2'd3;

	function automatic logic near(input logic [15:0] t, input logic [13:0] nominal,
			input logic [11:0] tol);
		logic [16:0] lo;
		logic [16:0] hi;
		lo = 17'(nominal) - 17'(tol);
		hi = 17'(nominal) + 17'(tol);
		return (17'(t) > lo) && (17'(t) < hi);
	endfunction

	logic [15:0] addr_q;
	logic [11:0] lm_tol_q;
	logic [10:0] ls_tol_q;
	logic [8:0] bit_tol_q;

	logic s1_valid;
	in_beat_t s1_data;

	// Captures seen, saturating at three: only 0, 1, 2 and "three or more" matter
	logic [1:0] cap_q;
	logic mark_pending_q;
	logic mark_ok_q;
	status_t first_err_q;
	logic [BCW-1:0] bit_count_q;
	logic [31:0] code_q;

	logic out_valid_q;
	out_beat_t out_q;

	logic blocked;
	logic s1_go;
	logic in_take;
	logic capture_go;
	logic timeout_go;
	check_t verdict;
	out_beat_t result;
	logic [6:0] bc_ext;
	logic near_short;
	logic near_long;

	assign blocked = (s1_data.cmd == CMD_TIMEOUT) && out_valid_q && out_stall;
	assign s1_go = s1_valid && !blocked;
	assign in_stall = s1_valid && blocked;
	assign in_take = in_valid && !in_stall;
	assign capture_go = s1_go && (s1_data.cmd == CMD_CAPTURE);
	assign timeout_go = s1_go && (s1_data.cmd == CMD_TIMEOUT);

	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign out_data = out_q;

	assign bc_ext = 7'(bit_count_q);
	assign near_short = near(s1_data.interval_us, BIT_SHORT_US, 12'(bit_tol_q));
	assign near_long = near(s1_data.interval_us, BIT_LONG_US, 12'(bit_tol_q));

	nipd_frame_check u_check (
		.code(code_q),
		.expected_address(addr_q),
		.verdict(verdict)
	);

	always_comb begin
		result.status = verdict.status;
		result.key_index = verdict.row;
		result.key_char = verdict.key_char;
		result.received_code = code_q;
		priority if (cap_q == 2'd0) begin
			result.status = ST_IDLE;
		end else if (first_err_q != ST_OK) begin
			result.status = first_err_q;
		end else if (cap_q != CAP_SAT) begin
			result.status = ST_LEADER;
		end else begin
			result.status = verdict.status;
		end
		if (result.status != ST_OK) begin
			result.key_index = '0;
			result.key_char = NO_CHAR;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			addr_q <= ADDR_RESET;
			lm_tol_q <= LEADER_MARK_TOL_RESET;
			ls_tol_q <= LEADER_SPACE_TOL_RESET;
			bit_tol_q <= BIT_TOL_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_ADDRESS: addr_q <= cfg_data;
				CFG_LEADER_MARK_TOL: lm_tol_q <= cfg_data[11:0];
				CFG_LEADER_SPACE_TOL: ls_tol_q <= cfg_data[10:0];
				CFG_BIT_TOL: bit_tol_q <= cfg_data[8:0];
				default: ;
			endcase
		end
	end

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid <= 1'b0;
		end else if (in_take) begin
			s1_valid <= 1'b1;
		end else if (s1_go) begin
			s1_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			s1_data <= in_data;
		end
	end

	// Frame state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= '0;
			mark_pending_q <= 1'b0;
			mark_ok_q <= 1'b0;
			first_err_q <= ST_OK;
			bit_count_q <= '0;
			code_q <= '0;
		end else if (timeout_go) begin
			cap_q <= '0;
			mark_pending_q <= 1'b0;
			mark_ok_q <= 1'b0;
			first_err_q <= ST_OK;
			bit_count_q <= '0;
			code_q <= '0;
		end else if (capture_go) begin
			if (cap_q != CAP_SAT) begin
				cap_q <= cap_q + 2'd1;
			end
			unique case (cap_q)
				2'd0: ;
				2'd1: begin
					if (!near(s1_data.interval_us, LEADER_MARK_US, lm_tol_q)
							&& first_err_q == ST_OK) begin
						first_err_q <= ST_LEADER;
					end
				end
				2'd2: begin
					if (!near(s1_data.interval_us, LEADER_SPACE_US, 12'(ls_tol_q))
							&& first_err_q == ST_OK) begin
						first_err_q <= ST_LEADER;
					end
				end
				default: begin
					if (!mark_pending_q) begin
						mark_pending_q <= 1'b1;
						mark_ok_q <= near_short;
					end else begin
						mark_pending_q <= 1'b0;
						if (first_err_q == ST_OK) begin
							priority if (!mark_ok_q) begin
								first_err_q <= ST_MARK;
							end else if (near_short || near_long) begin
								// store the bit, drop it past the code width
								if (bit_count_q < BC_MAX) begin
									if (bc_ext < 7'd32 && !near_short) begin
										code_q[bc_ext[4:0]] <= 1'b1;
									end
									bit_count_q <= bit_count_q + BCW'(1);
								end
							end else begin
								first_err_q <= ST_SPACE;
							end
						end
					end
				end
			endcase
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (timeout_go) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (timeout_go) begin
			out_q <= result;
		end
	end

`ifndef SYNTHESIS
	a_clear_after_timeout: assert property (@(posedge clk) disable iff (!arst_n)
		timeout_go |=> (cap_q == 2'd0 && bit_count_q == '0 && code_q == '0
			&& !mark_pending_q && first_err_q == ST_OK))
		else $error("frame state not cleared after timeout");

	a_ok_has_key: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_q.status == ST_OK) |->
			(out_q.key_index < 5'(TABLE_ROWS) && out_q.key_char != NO_CHAR))
		else $error("ok result without a key");

	a_mark_after_leader: assert property (@(posedge clk) disable iff (!arst_n)
		mark_pending_q |-> cap_q == CAP_SAT)
		else $error("bit mark pending before leader complete");

	a_bit_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		bit_count_q <= BC_MAX)
		else $error("bit count past code width");
`endif

endmodule
